/* src/psm_pkg.sv */
// Shared constants and control structs for the per-pixel stack median block.
package psm_pkg;

  localparam int PSM_MAX_IMAGES = 16;
  localparam int PIX_W          = 8;
  localparam int CFG_W          = 5;
  localparam int NUM_CH         = 3;
  localparam int DATA_W         = NUM_CH * PIX_W;

  typedef struct packed {
    logic insert;   // shift the accepted sample into the sorted rows
    logic pick;     // load the median into the output register
  } psm_cmd_t;

  typedef struct packed {
    logic out_free; // output register empty or draining this cycle
  } psm_stat_t;

endpackage

/* src/per_pixel_stack_median_unit.sv */
// Top level of the per-pixel temporal median (background estimation) unit.
//
// Usage:
//   in_*  : one transfer per image sample of the current pixel location,
//           tdata = {blue, green, red}, red in the lowest byte.
//   out_* : one transfer per completed stack carrying the per-channel
//           median (sorted element at index count/2, upper median for an
//           even count), same byte order as the input.
//   cfg_* : image count register, 5 bits; 0 acts as 1, values above MAX_IMAGES
//           act as MAX_IMAGES. The user must write it only while idle; unchecked.
// Operation:
//   Each sample is slotted into a sorted row per channel by a parallel
//   compare-and-shift. After the sample that closes a stack, the
//   sequencer enters its pick state, in which the median is read from
//   the sorted rows into the output register; no sample is taken in
//   that state.
// Stalls and reset:
//   Further samples are taken while a result waits in the output register;
//   only the next closing sample holds in its pick cycle until it drains.
//   Reset (rst_n low, synchronous) empties the stack, drops any pending
//   result and sets the image count to 1. Sample rows need no reset.
module per_pixel_stack_median_unit import psm_pkg::*; #(
  parameter int MAX_IMAGES = PSM_MAX_IMAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: image_count
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  // samples
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  // medians
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata   // [7:0] median_red, [15:8] median_green,
                                        // [23:16] median_blue
);

  localparam int CNT_W = $clog2(MAX_IMAGES + 1);
  localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;

  psm_cmd_t         cmd;
  psm_stat_t        stat;
  logic [CNT_W-1:0] fill_count;
  logic [IDX_W-1:0] med_idx;

  psm_ctrl #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .stat       (stat),
    .cmd        (cmd),
    .fill_count (fill_count),
    .med_idx    (med_idx)
  );

  psm_dp #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .fill_count (fill_count),
    .med_idx    (med_idx),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* src/psm_ctrl.sv */
// Controller: sample counter, image count register and two-state sequencer.
module psm_ctrl import psm_pkg::*; #(
  parameter int MAX_IMAGES = PSM_MAX_IMAGES,
  localparam int CNT_W = $clog2(MAX_IMAGES + 1),
  localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  psm_stat_t        stat,
  output psm_cmd_t         cmd,
  output logic [CNT_W-1:0] fill_count,
  output logic [IDX_W-1:0] med_idx
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PICK = 1'b1;

  logic             state_r, state_nxt;
  logic [CFG_W-1:0] image_count_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] med_idx_r, med_idx_nxt;
  logic [7:0]       cfg_ext;
  logic [CNT_W-1:0] target;
  logic [CNT_W-1:0] count_inc;
  logic             accept;
  logic             done;

  assign cfg_ready = 1'b1;

  // clamp the count to 1..MAX_IMAGES
  assign cfg_ext = {{(8-CFG_W){1'b0}}, image_count_r};
  always_comb begin
    if (cfg_ext == 8'd0) begin
      target = CNT_W'(1);
    end else if (cfg_ext > 8'(MAX_IMAGES)) begin
      target = CNT_W'(MAX_IMAGES);
    end else begin
      target = CNT_W'(cfg_ext);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign count_inc = count_r + CNT_W'(1);
  assign done      = (count_inc >= target);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    med_idx_nxt = med_idx_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.insert = 1'b1;
          if (done) begin
            count_nxt   = '0;
            med_idx_nxt = IDX_W'(count_inc >> 1);
            state_nxt   = ST_PICK;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      ST_PICK: begin
        if (stat.out_free) begin
          cmd.pick  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      image_count_r <= CFG_W'(1);
      med_idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      med_idx_r <= med_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        image_count_r <= cfg_data;
      end
    end
  end

  assign fill_count = count_r;
  assign med_idx    = med_idx_r;

endmodule

/* src/psm_dp.sv */
// Datapath: per-channel sorted insertion rows and the result register.
module psm_dp import psm_pkg::*; #(
  parameter int MAX_IMAGES = PSM_MAX_IMAGES,
  localparam int CNT_W = $clog2(MAX_IMAGES + 1),
  localparam int IDX_W = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  psm_cmd_t          cmd,
  output psm_stat_t         stat,
  input  logic [CNT_W-1:0]  fill_count,
  input  logic [IDX_W-1:0]  med_idx,
  input  logic [DATA_W-1:0] in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata
);

  logic [PIX_W-1:0] sorted_r   [NUM_CH][MAX_IMAGES];
  logic [PIX_W-1:0] sorted_nxt [NUM_CH][MAX_IMAGES];
  logic [MAX_IMAGES-1:0] gt    [NUM_CH];
  logic [DATA_W-1:0] out_data_r;
  logic              out_valid_r;

  // entries above the new sample move up one place, the sample drops in
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < MAX_IMAGES; i++) begin
        gt[c][i] = (CNT_W'(i) < fill_count) &&
                   (sorted_r[c][i] > in_tdata[c*PIX_W +: PIX_W]);
      end
      for (int i = 0; i < MAX_IMAGES; i++) begin
        if (i > 0 && gt[c][(i > 0) ? i-1 : 0]) begin
          sorted_nxt[c][i] = sorted_r[c][(i > 0) ? i-1 : 0];
        end else if (gt[c][i] || !(CNT_W'(i) < fill_count)) begin
          sorted_nxt[c][i] = in_tdata[c*PIX_W +: PIX_W];
        end else begin
          sorted_nxt[c][i] = sorted_r[c][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      sorted_r <= sorted_nxt;
    end
    if (cmd.pick) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_data_r[c*PIX_W +: PIX_W] <= sorted_r[c][med_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pick) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

endmodule
